>>> design/kcrt_pkg.sv
`default_nettype none

package kcrt_pkg;

    // Number of digits in the keypad entry and the digit store.
    localparam int ENTRY_DIGITS = 3;
    // Number of seven-segment positions driven.
    localparam int SHOW_DIGITS  = 3;

    localparam int FUNC_W  = 1;
    localparam int KEY_W   = 4;
    localparam int DIGIT_W = 4;
    localparam int SEG_W   = 7;
    localparam int SEC_W   = 16;
    localparam int MODE_W  = 3;

    localparam int IDX_W = (ENTRY_DIGITS > 1) ? $clog2(ENTRY_DIGITS) : 1;

    // Largest value the entry can display, plus one.
    localparam int DEC_LIMIT = 10 ** ENTRY_DIGITS;
    // Entry value with every digit at its largest stored code fits in this width.
    localparam int ENT_W     = $clog2(11 * DEC_LIMIT);
    localparam int SCALED_W  = ENT_W + 6;

    localparam logic [SEC_W-1:0] SEC_PER_MIN = SEC_W'(60);
    localparam logic [SEC_W-1:0] SEC_MAX     = {SEC_W{1'b1}};

    // floor(s / 60) == (s * MIN_RECIP) >> MIN_SHIFT for every 16-bit s.
    localparam int MIN_RECIP_W = 17;
    localparam int MIN_SHIFT   = 22;
    localparam int PROD_W      = SEC_W + MIN_RECIP_W;
    localparam logic [MIN_RECIP_W-1:0] MIN_RECIP = MIN_RECIP_W'(69906);

    // Binary to BCD conversion of the count, one bit per step.
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int CONV_STEPS = SEC_W;
    localparam int CNT_W      = $clog2(CONV_STEPS);

    localparam logic [MODE_W-1:0] MODE_RESET   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN_ON  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SEC_ON  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MIN_OFF = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SEC_OFF = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RUN     = 3'd5;

    localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_KEY  = 1'b1;

    localparam logic [KEY_W-1:0] KEY_DIGIT_LIMIT = 4'd10;
    localparam logic [KEY_W-1:0] KEY_STAR        = 4'd10;
    localparam logic [KEY_W-1:0] KEY_HASH        = 4'd11;

    localparam logic [DIGIT_W-1:0] DIGIT_ZERO = 4'd0;
    localparam logic [DIGIT_W-1:0] DASH_CODE  = 4'd10;

    localparam logic [SEG_W-1:0] SEG_DASH  = 7'h40;
    localparam logic [SEG_W-1:0] SEG_BLANK = 7'h00;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [KEY_W-1:0]  key;
    } item_t;

    typedef struct packed {
        logic [SEG_W-1:0]  seg_ones;
        logic [SEG_W-1:0]  seg_tens;
        logic [SEG_W-1:0]  seg_hundreds;
        logic              relay;
        logic [SEC_W-1:0]  remaining_seconds;
        logic [MODE_W-1:0] mode_code;
    } result_t;

    typedef struct packed {
        logic             capture;
        logic             apply;
        logic             entry_step;
        logic             load_count;
        logic             check;
        logic             conv_step;
        logic             show;
        logic             out_load;
        logic [IDX_W-1:0] idx;
    } dp_cmd_t;

    typedef struct packed {
        logic run_start;
        logic secs_nonzero;
    } dp_status_t;

    function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] d);
        logic [SEG_W-1:0] s;
        case (d)
            4'd0:      s = 7'h3F;
            4'd1:      s = 7'h06;
            4'd2:      s = 7'h5B;
            4'd3:      s = 7'h4F;
            4'd4:      s = 7'h66;
            4'd5:      s = 7'h6D;
            4'd6:      s = 7'h7D;
            4'd7:      s = 7'h07;
            4'd8:      s = 7'h7F;
            4'd9:      s = 7'h67;
            DASH_CODE: s = SEG_DASH;
            default:   s = SEG_BLANK;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/kcrt_datapath.sv
`default_nettype none

module kcrt_datapath (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire kcrt_pkg::item_t      item,
    input  wire kcrt_pkg::dp_cmd_t    cmd,
    output kcrt_pkg::dp_status_t      status,
    output kcrt_pkg::result_t         result
);
    import kcrt_pkg::*;

    logic [FUNC_W-1:0]  func_reg, func_next;
    logic [KEY_W-1:0]   key_reg, key_next;

    logic [MODE_W-1:0]  mode_reg, mode_next;
    logic [DIGIT_W-1:0] digit_reg  [ENTRY_DIGITS];
    logic [DIGIT_W-1:0] digit_next [ENTRY_DIGITS];
    logic               min_res_reg, min_res_next;
    logic               end_on_reg, end_on_next;
    logic               end_off_reg, end_off_next;
    logic [SEC_W-1:0]   secs_reg, secs_next;
    logic               relay_reg, relay_next;

    logic [ENT_W-1:0]   ent_reg, ent_next;
    logic [SEC_W-1:0]   conv_val_reg, conv_val_next;
    logic [SEC_W-1:0]   bin_reg, bin_next;
    logic [BCD_W-1:0]   bcd_reg, bcd_next;
    result_t            result_reg, result_next;

    logic [SEC_W-1:0]    secs_dec;
    logic [MODE_W-1:0]   mode_plus;
    logic [SCALED_W-1:0] scaled;
    logic [PROD_W-1:0]   prod;
    logic [SEC_W-1:0]    quot;
    logic                min_res_kept;
    logic [BCD_W-1:0]    bcd_adj;
    logic                over_range;
    logic                relay_out;
    logic [DIGIT_W-1:0]  shown [SHOW_DIGITS];

    assign secs_dec   = secs_reg - SEC_W'(1);
    assign mode_plus  = mode_reg + MODE_W'(1);
    assign prod       = PROD_W'(secs_reg) * PROD_W'(MIN_RECIP);
    assign quot       = SEC_W'(prod >> MIN_SHIFT);
    assign over_range = (32'(conv_val_reg) >= 32'(DEC_LIMIT));
    assign scaled     = min_res_reg ? ((SCALED_W'(ent_reg) << 6) - (SCALED_W'(ent_reg) << 2))
                                    : SCALED_W'(ent_reg);
    assign min_res_kept = min_res_reg && (secs_reg >= SEC_PER_MIN);

    // Display positions beyond the entry width show zero.
    for (genvar j = 0; j < SHOW_DIGITS; j++) begin : g_shown
        if (j < ENTRY_DIGITS) begin : g_live
            assign shown[j] = digit_reg[j];
        end
        else begin : g_pad
            assign shown[j] = DIGIT_ZERO;
        end
    end

    always_comb
    begin
        for (int j = 0; j < BCD_DIGITS; j++) begin
            if (bcd_reg[j*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                bcd_adj[j*DIGIT_W +: DIGIT_W] = bcd_reg[j*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
            else begin
                bcd_adj[j*DIGIT_W +: DIGIT_W] = bcd_reg[j*DIGIT_W +: DIGIT_W];
            end
        end
    end

    always_comb
    begin
        relay_out = relay_reg;
        if (end_on_reg) begin
            relay_out = 1'b1;
        end
        else if (end_off_reg && (secs_reg != '0)) begin
            relay_out = 1'b1;
        end
        if (!end_on_reg && !end_off_reg) begin
            relay_out = 1'b0;
        end
    end

    always_comb
    begin
        func_next     = func_reg;
        key_next      = key_reg;
        mode_next     = mode_reg;
        digit_next    = digit_reg;
        min_res_next  = min_res_reg;
        end_on_next   = end_on_reg;
        end_off_next  = end_off_reg;
        secs_next     = secs_reg;
        relay_next    = relay_reg;
        ent_next      = ent_reg;
        conv_val_next = conv_val_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        result_next   = result_reg;

        if (cmd.capture) begin
            func_next = item.func;
            key_next  = item.key;
        end

        if (cmd.apply) begin
            ent_next = '0;
            if (func_reg == FUNC_TICK) begin
                if (secs_reg != '0) begin
                    secs_next = secs_dec;
                    if (secs_dec == '0) begin
                        if (!end_off_reg) begin
                            end_on_next = 1'b1;
                        end
                        else begin
                            end_off_next = 1'b0;
                            end_on_next  = 1'b0;
                        end
                        for (int i = 0; i < ENTRY_DIGITS; i++) begin
                            digit_next[i] = DIGIT_ZERO;
                        end
                    end
                end
            end
            else begin
                unique case (key_reg)
                    KEY_STAR:
                    begin
                        if (mode_reg <= MODE_MIN_OFF) begin
                            mode_next = mode_plus;
                            for (int i = 1; i < ENTRY_DIGITS; i++) begin
                                digit_next[i] = DASH_CODE;
                            end
                            digit_next[0] = DIGIT_W'(mode_plus);
                        end
                        else if (mode_reg == MODE_SEC_OFF) begin
                            mode_next = MODE_RESET;
                            for (int i = 0; i < ENTRY_DIGITS; i++) begin
                                digit_next[i] = DIGIT_ZERO;
                            end
                        end
                        else if (mode_reg == MODE_RUN) begin
                            mode_next   = MODE_RESET;
                            end_on_next = 1'b0;
                            secs_next   = '0;
                            relay_next  = 1'b0;
                            for (int i = 0; i < ENTRY_DIGITS; i++) begin
                                digit_next[i] = DIGIT_ZERO;
                            end
                        end
                    end
                    KEY_HASH:
                    begin
                        // Starting a count from the run mode is sequenced separately.
                        if ((mode_reg >= MODE_MIN_ON) && (mode_reg <= MODE_SEC_OFF)) begin
                            min_res_next = (mode_reg == MODE_MIN_ON) ||
                                           (mode_reg == MODE_MIN_OFF);
                            end_on_next  = 1'b0;
                            end_off_next = (mode_reg >= MODE_MIN_OFF);
                            for (int i = 0; i < ENTRY_DIGITS; i++) begin
                                digit_next[i] = DIGIT_ZERO;
                            end
                        end
                    end
                    default:
                    begin
                        if ((key_reg < KEY_DIGIT_LIMIT) && (mode_reg != MODE_RESET) &&
                            (digit_reg[ENTRY_DIGITS-1] == DIGIT_ZERO)) begin
                            for (int i = ENTRY_DIGITS - 1; i > 0; i--) begin
                                digit_next[i] = digit_reg[i-1];
                            end
                            digit_next[0] = DIGIT_W'(key_reg);
                            mode_next     = MODE_RUN;
                        end
                    end
                endcase
            end
        end

        if (cmd.entry_step) begin
            ent_next = (ent_reg << 3) + (ent_reg << 1) + ENT_W'(digit_reg[cmd.idx]);
        end

        if (cmd.load_count) begin
            if (scaled > SCALED_W'(SEC_MAX)) begin
                secs_next = SEC_MAX;
            end
            else begin
                secs_next = scaled[SEC_W-1:0];
            end
        end

        if (cmd.check) begin
            min_res_next  = min_res_kept;
            conv_val_next = min_res_kept ? quot : secs_reg;
            bin_next      = min_res_kept ? quot : secs_reg;
            bcd_next      = '0;
        end

        if (cmd.conv_step) begin
            bcd_next = {bcd_adj[BCD_W-2:0], bin_reg[SEC_W-1]};
            bin_next = bin_reg << 1;
        end

        if (cmd.show) begin
            for (int i = 0; i < ENTRY_DIGITS; i++) begin
                digit_next[i] = over_range ? DIGIT_ZERO : bcd_reg[i*DIGIT_W +: DIGIT_W];
            end
        end

        if (cmd.out_load) begin
            relay_next                    = relay_out;
            result_next.seg_ones          = seg_of(shown[0]);
            result_next.seg_tens          = seg_of(shown[1]);
            result_next.seg_hundreds      = seg_of(shown[2]);
            result_next.relay             = relay_out;
            result_next.remaining_seconds = secs_reg;
            result_next.mode_code         = mode_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_RESET;
            min_res_reg <= 1'b0;
            end_on_reg  <= 1'b0;
            end_off_reg <= 1'b0;
            secs_reg    <= '0;
            relay_reg   <= 1'b0;
            for (int i = 0; i < ENTRY_DIGITS; i++) begin
                digit_reg[i] <= DIGIT_ZERO;
            end
        end
        else begin
            mode_reg    <= mode_next;
            min_res_reg <= min_res_next;
            end_on_reg  <= end_on_next;
            end_off_reg <= end_off_next;
            secs_reg    <= secs_next;
            relay_reg   <= relay_next;
            digit_reg   <= digit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg     <= func_next;
        key_reg      <= key_next;
        ent_reg      <= ent_next;
        conv_val_reg <= conv_val_next;
        bin_reg      <= bin_next;
        bcd_reg      <= bcd_next;
        result_reg   <= result_next;
    end

    assign status.run_start    = (func_reg == FUNC_KEY) && (key_reg == KEY_HASH) &&
                                 (mode_reg == MODE_RUN);
    assign status.secs_nonzero = (secs_reg != '0);
    assign result              = result_reg;

endmodule

`default_nettype wire

>>> design/kcrt_ctrl.sv
`default_nettype none

module kcrt_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    input  wire kcrt_pkg::dp_status_t  status,
    output kcrt_pkg::dp_cmd_t          cmd
);
    import kcrt_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_APPLY = 3'd1;
    localparam logic [2:0] S_ENTRY = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_CONV  = 3'd5;
    localparam logic [2:0] S_SHOW  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.idx        = cnt_reg[IDX_W-1:0];
        item_ready     = 1'b0;

        if (out_valid_reg && result_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = S_APPLY;
                end
            end
            S_APPLY:
            begin
                cmd.apply = 1'b1;
                if (status.run_start) begin
                    cnt_next   = CNT_W'(ENTRY_DIGITS - 1);
                    state_next = S_ENTRY;
                end
                else begin
                    state_next = S_CHECK;
                end
            end
            S_ENTRY:
            begin
                // Most significant digit first.
                cmd.entry_step = 1'b1;
                if (cnt_reg == '0) begin
                    state_next = S_LOAD;
                end
                else begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_LOAD:
            begin
                cmd.load_count = 1'b1;
                state_next     = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.secs_nonzero) begin
                    cmd.check  = 1'b1;
                    cnt_next   = '0;
                    state_next = S_CONV;
                end
                else begin
                    state_next = S_OUT;
                end
            end
            S_CONV:
            begin
                cmd.conv_step = 1'b1;
                if (cnt_reg == CNT_W'(CONV_STEPS - 1)) begin
                    state_next = S_SHOW;
                end
                else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_SHOW:
            begin
                cmd.show   = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_valid_reg || result_ready) begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> design/keypad_countdown_relay_timer_top.sv
`default_nettype none

// Countdown relay timer. Each input beat is either a one-second tick or a
// keypad key (digits 0-9, star, hash); each input beat produces exactly one
// result beat carrying three seven-segment codes, the relay level, the
// seconds left and the current mode code. Items are handled one at a time:
// a hash that starts a count first builds the entered value digit by digit,
// and whenever a count is live the remaining time goes through a 16-step
// bit-serial binary to BCD conversion before the result is offered. A new
// input beat is taken as soon as the previous result has been loaded into
// the output register, even if the downstream side has not yet taken it.
module keypad_countdown_relay_timer_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               item_valid,
    output logic                    item_ready,
    input  wire kcrt_pkg::item_t    item,
    output logic                    result_valid,
    input  wire logic               result_ready,
    output kcrt_pkg::result_t       result
);
    import kcrt_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences each beat: apply the key or tick, build the
    // entered value when a count starts, then convert the remaining time for
    // the display and hold the result until it is taken.
    kcrt_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    // The datapath holds the mode, the digit store, the count, the relay
    // flags and the output register.
    kcrt_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

endmodule

`default_nettype wire
